/* rtl/core/u8sb_pkg.sv */
// shared types and constants for the utf-8 to single-byte charset converter
// no dependencies; used by every module under rtl/core except u8sb_fifo
`default_nettype none

package u8sb_pkg;

    // default sizing handed to the top level
    localparam int MAP_DEPTH_DEF   = 1024;
    localparam int RANGE_COUNT_DEF = 4;
    localparam int RANGE_MAX       = 4;
    localparam int CMD_Q_DEPTH     = 4;

    // widths of the fixed fields
    localparam int CP_W     = 21;
    localparam int LEN_W    = 11;
    localparam int OFF_W    = 13;
    localparam int ADDR_W   = 17;
    localparam int ERR_W    = 32;
    localparam int ARG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 21;

    // code point limits
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_MIN_2B = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN_3B = 21'h00800;
    localparam logic [CP_W-1:0] CP_MIN_4B = 21'h10000;

    // input operations
    localparam logic [1:0] OP_FEED  = 2'd0;
    localparam logic [1:0] OP_EOS   = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    // work passed from the decoder to the lookup side
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_LIT    = 3'd1;
    localparam logic [2:0] CMD_ERR    = 3'd2;
    localparam logic [2:0] CMD_LOOKUP = 3'd3;
    localparam logic [2:0] CMD_WRITE  = 3'd4;

    // configuration index low bit: base or length of a range
    localparam logic CFG_SEL_BASE = 1'b0;

    // one queue entry: an optional leading error, then one operation
    // write argument: map_index in [9:0], map_value in [18:10]
    typedef struct packed {
        logic             has_err;
        logic [ERR_W-1:0] err0;
        logic [2:0]       op;
        logic [ARG_W-1:0] arg;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/core/utf8_to_single_byte_charset.sv */
// UTF-8 to single-byte charset converter.
// Input stream s_axis: one transaction per operation (tuser): feed a byte,
// end of stream, or write one entry of the byte map. Output stream m_axis:
// one transaction per result (tuser = kind: byte, decoding error, unknown
// code point), tlast on the final result of an input transaction.
// Range registers (base and length of up to four code ranges, packed one
// after another in the map) are to be written by the user on the cfg channel
// only while idle; the block itself does not enforce it. o_cfg_ready is always high.
// Throughput: one input transaction per cycle while the command queue is not full. An input
// that gives two results (a sequence broken by a fresh byte) holds the lookup stage
// until both are out; a four-entry command queue absorbs the difference.
// A result passes through the command queue, then the result stage (range match
// and registered map read), then the output register.
// Reset clears the decoder state, range registers and command queue; the map memory
// is not cleared and must be written before it is used.
// When m_axis_tready is low the output register holds, the lookup stage and
// queue fill, and s_axis_tready drops once the queue is full.
// depends on u8sb_pkg, u8sb_front, u8sb_fifo, u8sb_back
`default_nettype none

module utf8_to_single_byte_charset #(
    parameter int MAP_DEPTH   = u8sb_pkg::MAP_DEPTH_DEF,
    parameter int RANGE_COUNT = u8sb_pkg::RANGE_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [31:0]                       s_axis_tdata,  // byte_in, map_index, map_value
    input  wire logic [1:0]                        s_axis_tuser,  // operation
    // output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [63:0]                            m_axis_tdata,  // out_byte, error_bytes, code_point
    output logic [1:0]                             m_axis_tuser,  // kind
    output logic                                   m_axis_tlast,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [u8sb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [u8sb_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int CMD_W = $bits(u8sb_pkg::t_cmd);

    u8sb_pkg::t_cmd              q_in;
    u8sb_pkg::t_cmd              q_out;
    logic [CMD_W-1:0]            q_rdata;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    logic [1:0]                  out_kind;
    logic [7:0]                  out_byte;
    logic [u8sb_pkg::ERR_W-1:0]  out_err;
    logic [u8sb_pkg::CP_W-1:0]   out_cp;

    assign o_cfg_ready = 1'b1;

    // decoder
    u8sb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_q_full(q_full),
        .i_op    (s_axis_tuser),
        .i_byte  (s_axis_tdata[7:0]),
        .i_index (s_axis_tdata[17:8]),
        .i_value (s_axis_tdata[26:18]),
        .o_ready (s_axis_tready),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    // command queue
    u8sb_fifo #(
        .W    (CMD_W),
        .DEPTH(u8sb_pkg::CMD_Q_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_wdata(q_in),
        .i_pop  (q_pop),
        .o_rdata(q_rdata),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    assign q_out = u8sb_pkg::t_cmd'(q_rdata);

    // range lookup and result output
    u8sb_back #(
        .MAP_DEPTH  (MAP_DEPTH),
        .RANGE_COUNT(RANGE_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_q_empty  (q_empty),
        .i_cmd      (q_out),
        .o_pop      (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_kind     (out_kind),
        .o_byte     (out_byte),
        .o_err      (out_err),
        .o_cp       (out_cp),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {3'd0, out_cp, out_err, out_byte};

    // the decoder never pushes into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    // a byte result carries no error bytes and no code point
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == u8sb_pkg::KIND_BYTE)) |->
        (m_axis_tdata[60:8] == '0))
        else $error("byte result with stray error or code point bits");

    // an unknown code point always comes from a valid multi-byte sequence
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == u8sb_pkg::KIND_UNKNOWN)) |->
        ((m_axis_tdata[60:40] >= u8sb_pkg::CP_MIN_2B) &&
         (m_axis_tdata[60:40] <= u8sb_pkg::CP_MAX)))
        else $error("unknown code point out of decodable range");

endmodule

`default_nettype wire

/* rtl/core/u8sb_front.sv */
// utf-8 decoder front end: tracks the open sequence and emits queue commands
// depends on u8sb_pkg
`default_nettype none

module u8sb_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_q_full,
    input  wire logic [1:0]     i_op,
    input  wire logic [7:0]     i_byte,
    input  wire logic [9:0]     i_index,
    input  wire logic [8:0]     i_value,
    output logic                o_ready,
    output logic                o_push,
    output u8sb_pkg::t_cmd      o_cmd
);

    logic [1:0]                  r_be, n_be;
    logic [1:0]                  r_br, n_br;
    logic [u8sb_pkg::CP_W-1:0]   r_ca, n_ca;
    logic [u8sb_pkg::ERR_W-1:0]  r_ea, n_ea;
    logic                        accept;
    logic                        intr;
    logic [1:0]                  be_eff;
    logic [u8sb_pkg::CP_W-1:0]   minimum;
    u8sb_pkg::t_cmd              cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // sequence decode for one transaction
    always_comb begin
        n_be    = r_be;
        n_br    = r_br;
        n_ca    = r_ca;
        n_ea    = r_ea;
        cmd     = '0;
        cmd.op  = u8sb_pkg::CMD_NONE;
        intr    = 1'b0;
        be_eff  = r_be;
        minimum = u8sb_pkg::CP_MIN_4B;
        if (accept) begin
            unique case (i_op)
                u8sb_pkg::OP_FEED: begin
                    // non-continuation byte while a sequence is open
                    intr        = (r_be != 2'd0) && (i_byte[7:6] != 2'b10);
                    cmd.has_err = intr;
                    cmd.err0    = r_ea;
                    be_eff      = intr ? 2'd0 : r_be;
                    if (be_eff == 2'd0) begin
                        n_ea = {24'd0, i_byte};
                        n_br = 2'd0;
                        n_be = 2'd0;
                        if (!i_byte[7]) begin
                            cmd.op  = u8sb_pkg::CMD_LIT;
                            cmd.arg = {24'd0, i_byte};
                        end else if (i_byte[7:5] == 3'b110) begin
                            n_ca = {16'd0, i_byte[4:0]};
                            n_be = 2'd1;
                        end else if (i_byte[7:4] == 4'b1110) begin
                            n_ca = {17'd0, i_byte[3:0]};
                            n_be = 2'd2;
                        end else if (i_byte[7:3] == 5'b11110) begin
                            n_ca = {18'd0, i_byte[2:0]};
                            n_be = 2'd3;
                        end else begin
                            cmd.op  = u8sb_pkg::CMD_ERR;
                            cmd.arg = {24'd0, i_byte};
                        end
                    end else begin
                        n_ea = {r_ea[23:0], i_byte};
                        n_ca = {r_ca[14:0], i_byte[5:0]};
                        n_br = r_br + 2'd1;
                        if (n_br >= r_be) begin
                            n_be = 2'd0;
                            if (r_be == 2'd1) begin
                                minimum = u8sb_pkg::CP_MIN_2B;
                            end else if (r_be == 2'd2) begin
                                minimum = u8sb_pkg::CP_MIN_3B;
                            end
                            if ((n_ca < minimum) || (n_ca > u8sb_pkg::CP_MAX)) begin
                                cmd.op  = u8sb_pkg::CMD_ERR;
                                cmd.arg = n_ea;
                            end else begin
                                cmd.op  = u8sb_pkg::CMD_LOOKUP;
                                cmd.arg = {11'd0, n_ca};
                            end
                        end
                    end
                end
                u8sb_pkg::OP_EOS: begin
                    if (r_be != 2'd0) begin
                        cmd.op  = u8sb_pkg::CMD_ERR;
                        cmd.arg = r_ea;
                        n_be    = 2'd0;
                    end
                end
                u8sb_pkg::OP_WRITE: begin
                    cmd.op  = u8sb_pkg::CMD_WRITE;
                    cmd.arg = {13'd0, i_value, i_index};
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push = cmd.has_err || (cmd.op != u8sb_pkg::CMD_NONE);
    assign o_cmd  = cmd;

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_be <= 2'd0;
            r_br <= 2'd0;
            r_ca <= '0;
            r_ea <= '0;
        end else begin
            r_be <= n_be;
            r_br <= n_br;
            r_ca <= n_ca;
            r_ea <= n_ea;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/u8sb_fifo.sv */
// small command queue between decoder and lookup side
// depends on no package; width and depth come from the instantiating module
`default_nettype none

module u8sb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  r_data [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_data[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wp] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/u8sb_back.sv */
// lookup back end: range registers, map memory, result sequencing and output register
// depends on u8sb_pkg
`default_nettype none

module u8sb_back #(
    parameter int MAP_DEPTH   = u8sb_pkg::MAP_DEPTH_DEF,
    parameter int RANGE_COUNT = u8sb_pkg::RANGE_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [u8sb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [u8sb_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  wire logic                              i_q_empty,
    input  wire u8sb_pkg::t_cmd                    i_cmd,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [1:0]                             o_kind,
    output logic [7:0]                             o_byte,
    output logic [u8sb_pkg::ERR_W-1:0]             o_err,
    output logic [u8sb_pkg::CP_W-1:0]              o_cp,
    output logic                                   o_last
);

    localparam int AW = $clog2(MAP_DEPTH);

    // range configuration and packed start offsets
    logic [u8sb_pkg::CP_W-1:0]   r_base [u8sb_pkg::RANGE_MAX];
    logic [u8sb_pkg::LEN_W-1:0]  r_len  [u8sb_pkg::RANGE_MAX];
    logic [u8sb_pkg::OFF_W-1:0]  r_off  [u8sb_pkg::RANGE_MAX];
    logic [u8sb_pkg::OFF_W-1:0]  n_off  [u8sb_pkg::RANGE_MAX];

    // map memory
    logic [8:0]                  mem [MAP_DEPTH];
    logic [8:0]                  r_rd;

    // lookup address of the queue head
    logic [u8sb_pkg::CP_W-1:0]   cp;
    logic [u8sb_pkg::CP_W:0]     diff;
    logic                        hit;
    logic [u8sb_pkg::OFF_W-1:0]  addr;
    logic [u8sb_pkg::ADDR_W-1:0] addr_wide;
    logic                        addr_ok;
    logic [u8sb_pkg::ADDR_W-1:0] wr_wide;
    logic                        wr_ok;

    // result stage
    logic                        r_s1_valid;
    logic                        r_phase;
    logic                        r_s1_has_err;
    logic [u8sb_pkg::ERR_W-1:0]  r_s1_err0;
    logic [2:0]                  r_s1_op;
    logic [u8sb_pkg::ARG_W-1:0]  r_s1_arg;
    logic                        r_s1_hit_ok;
    logic                        second_has;
    logic                        first;
    logic                        emit;
    logic                        final_res;
    logic                        out_free;
    logic                        out_load;
    logic                        s1_free;
    logic [1:0]                  res_kind;
    logic [7:0]                  res_byte;
    logic [u8sb_pkg::ERR_W-1:0]  res_err;
    logic [u8sb_pkg::CP_W-1:0]   res_cp;

    logic                        r_out_valid;
    logic [1:0]                  r_kind;
    logic [7:0]                  r_byte;
    logic [u8sb_pkg::ERR_W-1:0]  r_err;
    logic [u8sb_pkg::CP_W-1:0]   r_cp;
    logic                        r_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < u8sb_pkg::RANGE_MAX; i++) begin
                r_base[i] <= '0;
                r_len[i]  <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index[0] == u8sb_pkg::CFG_SEL_BASE) begin
                r_base[i_cfg_index[2:1]] <= i_cfg_data;
            end else begin
                r_len[i_cfg_index[2:1]] <= i_cfg_data[u8sb_pkg::LEN_W-1:0];
            end
        end
    end

    // running sum of range lengths gives each range's first map address
    always_comb begin
        n_off[0] = '0;
        for (int i = 1; i < u8sb_pkg::RANGE_MAX; i++) begin
            n_off[i] = n_off[i-1] + u8sb_pkg::OFF_W'(r_len[i-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < u8sb_pkg::RANGE_MAX; i++) begin
            r_off[i] <= n_off[i];
        end
    end

    // first matching range; walked downward so the lowest index wins
    always_comb begin
        cp   = i_cmd.arg[u8sb_pkg::CP_W-1:0];
        hit  = 1'b0;
        addr = '0;
        diff = '0;
        for (int i = RANGE_COUNT - 1; i >= 0; i--) begin
            diff = {1'b0, cp} - {1'b0, r_base[i]};
            if ((cp >= r_base[i]) && (diff < (u8sb_pkg::CP_W+1)'(r_len[i]))) begin
                hit  = 1'b1;
                addr = r_off[i] + u8sb_pkg::OFF_W'(diff[u8sb_pkg::LEN_W-1:0]);
            end
        end
    end

    assign addr_wide = u8sb_pkg::ADDR_W'(addr);
    assign addr_ok   = addr_wide < u8sb_pkg::ADDR_W'(MAP_DEPTH);
    assign wr_wide   = u8sb_pkg::ADDR_W'(i_cmd.arg[9:0]);
    assign wr_ok     = wr_wide < u8sb_pkg::ADDR_W'(MAP_DEPTH);

    // map memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == u8sb_pkg::CMD_WRITE) && wr_ok) begin
            mem[wr_wide[AW-1:0]] <= i_cmd.arg[18:10];
        end
        if (o_pop) begin
            r_rd <= mem[addr_wide[AW-1:0]];
        end
    end

    // result selection for the entry in the result stage
    always_comb begin
        case (r_s1_op)
            u8sb_pkg::CMD_LIT, u8sb_pkg::CMD_ERR, u8sb_pkg::CMD_LOOKUP: second_has = 1'b1;
            default: second_has = 1'b0;
        endcase
    end

    assign first     = r_s1_has_err && !r_phase;
    assign emit      = r_s1_valid && (first || second_has);
    assign final_res = !first || !second_has;
    assign out_free  = !r_out_valid || i_ready;
    assign out_load  = emit && out_free;
    assign s1_free   = !r_s1_valid || !emit || (out_load && final_res);
    assign o_pop     = !i_q_empty && s1_free;

    always_comb begin
        res_kind = u8sb_pkg::KIND_BYTE;
        res_byte = '0;
        res_err  = '0;
        res_cp   = '0;
        if (first) begin
            res_kind = u8sb_pkg::KIND_ERROR;
            res_err  = r_s1_err0;
        end else begin
            case (r_s1_op)
                u8sb_pkg::CMD_LIT: begin
                    res_byte = r_s1_arg[7:0];
                end
                u8sb_pkg::CMD_ERR: begin
                    res_kind = u8sb_pkg::KIND_ERROR;
                    res_err  = r_s1_arg;
                end
                u8sb_pkg::CMD_LOOKUP: begin
                    // entries of 256 and up mean no mapping
                    if (r_s1_hit_ok && !r_rd[8]) begin
                        res_byte = r_rd[7:0];
                    end else begin
                        res_kind = u8sb_pkg::KIND_UNKNOWN;
                        res_cp   = r_s1_arg[u8sb_pkg::CP_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= 1'b1;
            r_phase    <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= 1'b0;
        end else if (out_load) begin
            r_phase <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_has_err <= i_cmd.has_err;
            r_s1_err0    <= i_cmd.err0;
            r_s1_op      <= i_cmd.op;
            r_s1_arg     <= i_cmd.arg;
            r_s1_hit_ok  <= hit && addr_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind <= res_kind;
            r_byte <= res_byte;
            r_err  <= res_err;
            r_cp   <= res_cp;
            r_last <= final_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;
    assign o_byte  = r_byte;
    assign o_err   = r_err;
    assign o_cp    = r_cp;
    assign o_last  = r_last;

endmodule

`default_nettype wire
